// ===== rtl/scdt_pkg.sv =====
// ----------------------------------------------------------------------------
// scdt_pkg: shared types and constants for the civil date converter
// Field widths, calendar constants and the reciprocal multipliers that stand
// in for the constant divisions of the conversion.
// ----------------------------------------------------------------------------
package scdt_pkg;

   // Field widths of the input and result items.
   localparam int unsigned SECS_W   = 32;
   localparam int unsigned OFFSET_W = 4;
   localparam int unsigned SEC_W    = 6;
   localparam int unsigned MIN_W    = 6;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 12;
   localparam int unsigned RSP_DATA_W = 40;

   // Widths of the intermediate values, from the range of a 32-bit count.
   localparam int unsigned MINS_W  = 27;
   localparam int unsigned HOURS_W = 21;
   localparam int unsigned DAYS_W  = 16;
   localparam int unsigned JDN_W   = 22;
   localparam int unsigned B_W     = 7;
   localparam int unsigned C_W     = 17;
   localparam int unsigned D_W     = 7;
   localparam int unsigned E_W     = 9;
   localparam int unsigned M_W     = 4;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(8);

   // Calendar constants.
   localparam int unsigned SECS_PER_MIN      = 60;
   localparam int unsigned MINS_PER_HOUR     = 60;
   localparam int unsigned HOURS_PER_DAY     = 24;
   localparam int unsigned JDN_EPOCH_BIAS    = 2472632;
   localparam int unsigned DAYS_PER_400Y     = 146097;
   localparam int unsigned DAYS_PER_4Y       = 1461;
   localparam int unsigned DAYS_PER_5MON     = 153;
   localparam int unsigned YEAR_BIAS         = 4800;
   localparam int unsigned YEARS_PER_CENTURY = 100;
   localparam int unsigned MONTHS_PER_YEAR   = 12;
   localparam int unsigned MARCH_BASE        = 3;
   localparam int unsigned MONTH_WRAP_STEP   = 10;

   // Reciprocals: floor(n / d) == (n * ceil(2^k / d)) >> k over the range of n
   // seen at each point of the chain.
   localparam int unsigned MIN_SHIFT    = 37;
   localparam int unsigned HOUR_SHIFT   = 33;
   localparam int unsigned DAY_SHIFT    = 26;
   localparam int unsigned CYC400_SHIFT = 42;
   localparam int unsigned CYC4_SHIFT   = 30;
   localparam int unsigned MON_SHIFT    = 20;

   localparam logic [63:0] MIN_MAGIC =
      ((64'd1 << MIN_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN);
   localparam logic [63:0] HOUR_MAGIC =
      ((64'd1 << HOUR_SHIFT) + 64'(MINS_PER_HOUR) - 64'd1) / 64'(MINS_PER_HOUR);
   localparam logic [63:0] DAY_MAGIC =
      ((64'd1 << DAY_SHIFT) + 64'(HOURS_PER_DAY) - 64'd1) / 64'(HOURS_PER_DAY);
   localparam logic [63:0] CYC400_MAGIC =
      ((64'd1 << CYC400_SHIFT) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y);
   localparam logic [63:0] CYC4_MAGIC =
      ((64'd1 << CYC4_SHIFT) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y);
   localparam logic [63:0] MON_MAGIC =
      ((64'd1 << MON_SHIFT) + 64'(DAYS_PER_5MON) - 64'd1) / 64'(DAYS_PER_5MON);

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  min;
      logic [SEC_W-1:0]  sec;
   } scdt_hms_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } scdt_date_type;

   // Days from 1 March to the first of each month of the March-based year,
   // that is (153 * m + 2) / 5.
   function automatic logic [E_W-1:0] month_start(input logic [M_W-1:0] m);
      logic [E_W-1:0] days;
      unique case (m)
         M_W'(0):  days = E_W'(0);
         M_W'(1):  days = E_W'(31);
         M_W'(2):  days = E_W'(61);
         M_W'(3):  days = E_W'(92);
         M_W'(4):  days = E_W'(122);
         M_W'(5):  days = E_W'(153);
         M_W'(6):  days = E_W'(184);
         M_W'(7):  days = E_W'(214);
         M_W'(8):  days = E_W'(245);
         M_W'(9):  days = E_W'(275);
         M_W'(10): days = E_W'(306);
         M_W'(11): days = E_W'(337);
         default:  days = E_W'(0);
      endcase
      return days;
   endfunction

endpackage

// ===== rtl/seconds_to_civil_date_top.sv =====
// ----------------------------------------------------------------------------
// seconds_to_civil_date_top: Unix seconds to zoned civil date and time
// An item passes through every register stage of the constant-divisor chain
// before it shows on rsp_tvalid; one item is accepted every cycle while the
// result side does not stall the pipeline.
// Reset clears all stage valid bits and sets the zone offset to 8 hours.
// ----------------------------------------------------------------------------
module seconds_to_civil_date_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration: zone offset in whole hours.
   input  logic                                 csr_wr_en,
   input  logic [scdt_pkg::OFFSET_W-1:0]        csr_wr_data,
   // Input items.
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [scdt_pkg::SECS_W-1:0]          req_tdata,  // unix_seconds
   // Result items.
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
   // month_of_year, full_year, then two zero bits.
   output logic [scdt_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import scdt_pkg::*;

   localparam int unsigned RSP_PAD_W =
      RSP_DATA_W - (SEC_W + MIN_W + HOUR_W + DAY_W + MONTH_W + YEAR_W);

   // The zone offset register. The user must write it only while the block is
   // idle, which the block does not enforce, so the stage that adds it can read it directly.
   logic [OFFSET_W-1:0] zone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         zone_ff <= csr_wr_data;
      end
   end

   // The first five stages split the count into second, minute, zoned hour
   // and a biased day number. Each stage holds at most one reciprocal multiply and
   // one remainder subtraction, so the stages are of similar depth.
   logic            split_valid;
   logic            split_ready;
   scdt_hms_type    split_hms;
   logic [JDN_W-1:0] split_jdn;

   scdt_time_split u_time_split (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_seconds  (req_tdata),
      .zone_offset (zone_ff),
      .out_valid   (split_valid),
      .out_ready   (split_ready),
      .out_hms     (split_hms),
      .out_jdn     (split_jdn)
   );

   // The last six stages turn the day number into a Gregorian date. Their
   // final stage is the result register. Every stage loads whenever it is
   // empty or its content moves on, so a stalled result holds only the
   // stages behind it that are full, and bubbles close up.
   scdt_hms_type    date_hms;
   scdt_date_type   date_fields;

   scdt_jdn_date u_jdn_date (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_hms    (split_hms),
      .in_jdn    (split_jdn),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hms   (date_hms),
      .out_date  (date_fields)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, date_fields.year, date_fields.month,
                       date_fields.day, date_hms.hour, date_hms.min, date_hms.sec};

   // With the result register empty, every stage can load, so the input
   // side must be ready.
   a_ready_when_empty : assert property (
      @(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready
   ) else $error("input not ready while the result register is empty");

   // The valid bits come out of reset cleared.
   a_reset_clears : assert property (
      @(posedge clock)
      $past(reset) |-> !rsp_tvalid
   ) else $error("result valid directly after reset");

   // Every result lies within the calendar ranges.
   a_date_range : assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> (date_fields.month >= MONTH_W'(1) && date_fields.month <= MONTH_W'(12)
                      && date_fields.day >= DAY_W'(1))
   ) else $error("month or day of month out of range");

   a_time_range : assert property (
      @(posedge clock) disable iff (reset)
      rsp_tvalid |-> (date_hms.hour < HOUR_W'(24) && date_hms.min < MIN_W'(60)
                      && date_hms.sec < SEC_W'(60))
   ) else $error("time of day out of range");

endmodule

// ===== rtl/scdt_time_split.sv =====
// ----------------------------------------------------------------------------
// scdt_time_split: seconds, minutes and hours of a Unix count
// Five register stages split the count into second, minute, zoned hour of day
// and the biased Julian day number of the local date.
// ----------------------------------------------------------------------------
module scdt_time_split (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [scdt_pkg::SECS_W-1:0]    in_seconds,
   input  logic [scdt_pkg::OFFSET_W-1:0]  zone_offset,
   output logic                           out_valid,
   input  logic                           out_ready,
   output scdt_pkg::scdt_hms_type         out_hms,
   output logic [scdt_pkg::JDN_W-1:0]     out_jdn
);
   import scdt_pkg::*;

   localparam int unsigned NUM_STAGES = 5;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   // A stage loads when it is empty or when its content moves on.
   always_comb begin
      en[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = ~vld_ff[i] | en[i+1];
      end
   end

   assign vld_in   = {vld_ff[NUM_STAGES-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage 1: minutes since the epoch.
   logic [63:0]         prod1;
   logic [MINS_W-1:0]   mins1_in, mins1_ff;
   logic [SECS_W-1:0]   secs1_ff;

   assign prod1    = 64'(in_seconds) * MIN_MAGIC;
   assign mins1_in = prod1[MIN_SHIFT +: MINS_W];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         secs1_ff <= in_seconds;
         mins1_ff <= mins1_in;
      end
   end

   // Stage 2: second of minute and hours since the epoch.
   logic [63:0]          prod2;
   logic [HOURS_W-1:0]   hutc2_in, hutc2_ff;
   logic [SEC_W-1:0]     sec2_in, sec2_ff;
   logic [MINS_W-1:0]    mins2_ff;

   assign prod2    = 64'(mins1_ff) * HOUR_MAGIC;
   assign hutc2_in = prod2[HOUR_SHIFT +: HOURS_W];
   assign sec2_in  = SEC_W'(secs1_ff - SECS_W'(mins1_ff) * SECS_W'(SECS_PER_MIN));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hutc2_ff <= hutc2_in;
         sec2_ff  <= sec2_in;
         mins2_ff <= mins1_ff;
      end
   end

   // Stage 3: minute of hour and the zoned hour count.
   logic [MIN_W-1:0]     min3_in, min3_ff;
   logic [HOURS_W-1:0]   hours3_in, hours3_ff;
   logic [SEC_W-1:0]     sec3_ff;

   assign min3_in   = MIN_W'(mins2_ff - MINS_W'(hutc2_ff) * MINS_W'(MINS_PER_HOUR));
   assign hours3_in = hutc2_ff + HOURS_W'(zone_offset);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         min3_ff   <= min3_in;
         hours3_ff <= hours3_in;
         sec3_ff   <= sec2_ff;
      end
   end

   // Stage 4: local days since the epoch.
   logic [63:0]          prod4;
   logic [DAYS_W-1:0]    days4_in, days4_ff;
   logic [HOURS_W-1:0]   hours4_ff;
   logic [MIN_W-1:0]     min4_ff;
   logic [SEC_W-1:0]     sec4_ff;

   assign prod4    = 64'(hours3_ff) * DAY_MAGIC;
   assign days4_in = prod4[DAY_SHIFT +: DAYS_W];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         days4_ff  <= days4_in;
         hours4_ff <= hours3_ff;
         min4_ff   <= min3_ff;
         sec4_ff   <= sec3_ff;
      end
   end

   // Stage 5: hour of day and the biased day number.
   scdt_hms_type         hms5_in, hms5_ff;
   logic [JDN_W-1:0]     jdn5_in, jdn5_ff;

   always_comb begin
      hms5_in.sec  = sec4_ff;
      hms5_in.min  = min4_ff;
      hms5_in.hour = HOUR_W'(hours4_ff - HOURS_W'(days4_ff) * HOURS_W'(HOURS_PER_DAY));
   end

   assign jdn5_in = JDN_W'(days4_ff) + JDN_W'(JDN_EPOCH_BIAS);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         hms5_ff <= hms5_in;
         jdn5_ff <= jdn5_in;
      end
   end

   assign out_valid = vld_ff[NUM_STAGES-1];
   assign out_hms   = hms5_ff;
   assign out_jdn   = jdn5_ff;

endmodule

// ===== rtl/scdt_jdn_date.sv =====
// ----------------------------------------------------------------------------
// scdt_jdn_date: biased Julian day number to Gregorian date
// Six register stages run the 400-year, 4-year and five-month steps and give
// day of month, month and full year; the time fields ride alongside.
// ----------------------------------------------------------------------------
module scdt_jdn_date (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  scdt_pkg::scdt_hms_type      in_hms,
   input  logic [scdt_pkg::JDN_W-1:0]  in_jdn,
   output logic                        out_valid,
   input  logic                        out_ready,
   output scdt_pkg::scdt_hms_type      out_hms,
   output scdt_pkg::scdt_date_type     out_date
);
   import scdt_pkg::*;

   localparam int unsigned NUM_STAGES = 6;
   localparam int unsigned N400_W     = JDN_W + 2;
   localparam int unsigned P400_W     = B_W + 18;
   localparam int unsigned N4_W       = C_W + 2;
   localparam int unsigned P4_W       = D_W + 11;
   localparam int unsigned N5_W       = E_W + 3;
   localparam int unsigned YSUM_W     = 16;

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[NUM_STAGES-1] = ~vld_ff[NUM_STAGES-1] | out_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = ~vld_ff[i] | en[i+1];
      end
   end

   assign vld_in   = {vld_ff[NUM_STAGES-2:0], in_valid};
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage 1: the 400-year cycle count b = (4a + 3) / 146097.
   logic [N400_W-1:0]  n1;
   logic [63:0]        prod1;
   logic [B_W-1:0]     b1_in, b1_ff;
   logic [JDN_W-1:0]   jdn1_ff;
   scdt_hms_type       hms1_ff;

   assign n1    = {in_jdn, 2'b11};
   assign prod1 = 64'(n1) * CYC400_MAGIC;
   assign b1_in = prod1[CYC400_SHIFT +: B_W];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         b1_ff   <= b1_in;
         jdn1_ff <= in_jdn;
         hms1_ff <= in_hms;
      end
   end

   // Stage 2: days into the 400-year cycle.
   logic [P400_W-1:0]  t2;
   logic [C_W-1:0]     c2_in, c2_ff;
   logic [B_W-1:0]     b2_ff;
   scdt_hms_type       hms2_ff;

   assign t2    = P400_W'(b1_ff) * P400_W'(DAYS_PER_400Y);
   assign c2_in = C_W'(jdn1_ff - JDN_W'(t2 >> 2));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c2_ff   <= c2_in;
         b2_ff   <= b1_ff;
         hms2_ff <= hms1_ff;
      end
   end

   // Stage 3: the 4-year cycle count d = (4c + 3) / 1461.
   logic [N4_W-1:0]    n3;
   logic [63:0]        prod3;
   logic [D_W-1:0]     d3_in, d3_ff;
   logic [C_W-1:0]     c3_ff;
   logic [B_W-1:0]     b3_ff;
   scdt_hms_type       hms3_ff;

   assign n3    = {c2_ff, 2'b11};
   assign prod3 = 64'(n3) * CYC4_MAGIC;
   assign d3_in = prod3[CYC4_SHIFT +: D_W];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         d3_ff   <= d3_in;
         c3_ff   <= c2_ff;
         b3_ff   <= b2_ff;
         hms3_ff <= hms2_ff;
      end
   end

   // Stage 4: day of the March-based year.
   logic [P4_W-1:0]    t4;
   logic [E_W-1:0]     e4_in, e4_ff;
   logic [D_W-1:0]     d4_ff;
   logic [B_W-1:0]     b4_ff;
   scdt_hms_type       hms4_ff;

   assign t4    = P4_W'(d3_ff) * P4_W'(DAYS_PER_4Y);
   assign e4_in = E_W'(c3_ff - C_W'(t4 >> 2));

   always_ff @(posedge clock) begin
      if (en[3]) begin
         e4_ff   <= e4_in;
         d4_ff   <= d3_ff;
         b4_ff   <= b3_ff;
         hms4_ff <= hms3_ff;
      end
   end

   // Stage 5: month index from March, m = (5e + 2) / 153.
   logic [N5_W-1:0]    n5;
   logic [63:0]        prod5;
   logic [M_W-1:0]     m5_in, m5_ff;
   logic [E_W-1:0]     e5_ff;
   logic [D_W-1:0]     d5_ff;
   logic [B_W-1:0]     b5_ff;
   scdt_hms_type       hms5_ff;

   assign n5    = N5_W'(e4_ff) * N5_W'(5) + N5_W'(2);
   assign prod5 = 64'(n5) * MON_MAGIC;
   assign m5_in = prod5[MON_SHIFT +: M_W];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         m5_ff   <= m5_in;
         e5_ff   <= e4_ff;
         d5_ff   <= d4_ff;
         b5_ff   <= b4_ff;
         hms5_ff <= hms4_ff;
      end
   end

   // Stage 6: January and February belong to the following civil year.
   logic               wrap6;
   logic [YSUM_W-1:0]  ysum6;
   scdt_date_type      date6_in, date6_ff;
   scdt_hms_type       hms6_ff;

   assign wrap6 = (m5_ff >= M_W'(MONTH_WRAP_STEP));
   assign ysum6 = YSUM_W'(b5_ff) * YSUM_W'(YEARS_PER_CENTURY) + YSUM_W'(d5_ff)
                + YSUM_W'(wrap6) - YSUM_W'(YEAR_BIAS);

   always_comb begin
      date6_in.day   = DAY_W'(e5_ff - month_start(m5_ff) + E_W'(1));
      date6_in.month = wrap6 ? MONTH_W'(m5_ff + M_W'(MARCH_BASE) - M_W'(MONTHS_PER_YEAR))
                             : MONTH_W'(m5_ff + M_W'(MARCH_BASE));
      date6_in.year  = ysum6[YEAR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         date6_ff <= date6_in;
         hms6_ff  <= hms5_ff;
      end
   end

   assign out_valid = vld_ff[NUM_STAGES-1];
   assign out_hms   = hms6_ff;
   assign out_date  = date6_ff;

endmodule

// ===== bench/tb_seconds_to_civil_date_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seconds_to_civil_date_top: self-checking bench for the civil date converter
// Unix second counts are streamed in with random gaps, and results are taken
// with random back-pressure. Each accepted item is converted by a behavioural
// model of the calendar arithmetic using the zone offset in force at the time.
// Each result is then compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_seconds_to_civil_date_top;
   import scdt_pkg::*;

   // The result word as the block packs it, lowest field at the bottom.
   typedef struct packed {
      logic [1:0]         pad;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   min;
      logic [SEC_W-1:0]   sec;
   } civil_fields_type;

   // The pipeline is eleven stages deep; the drain wait allows a little more.
   localparam int unsigned PIPE_DRAIN = 20;
   localparam int unsigned MAX_IDLE   = 9;
   localparam int unsigned REPORT_MAX = 10;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [OFFSET_W-1:0]   csr_wr_data;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SECS_W-1:0]     req_tdata;   // unix_seconds
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // second_of_minute, minute_of_hour, hour_of_day, day_of_month,
   // month_of_year, full_year, then two zero bits.
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Predictions waiting for their result, oldest first.
   civil_fields_type pending_dates[$];
   logic [OFFSET_W-1:0] zone_hours = OFFSET_RESET;
   // When set, neither side inserts idle cycles.
   bit              calm = 1'b0;
   int unsigned     stamps_sent = 0;
   int unsigned     dates_checked = 0;
   int unsigned     fault_count = 0;
   logic [15:0]     zones_seen = '0;

   seconds_to_civil_date_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Calendar arithmetic on wide unsigned integers. The day number is turned
   // into a biased Julian day number, split into 400-year and 4-year cycles, and
   // the remaining day of the year is split into months with a March-based
   // year, in which each five months span 153 days.
   function automatic civil_fields_type civil_from_unix(input logic [SECS_W-1:0] stamp,
                                                        input logic [OFFSET_W-1:0] zone);
      longint unsigned secs, mins, hours, days, jdn;
      longint unsigned cycles_400, rest_400, cycles_4, rest_4, month_step, wrap;
      civil_fields_type f;
      secs       = longint'(stamp);
      mins       = secs / SECS_PER_MIN;
      hours      = mins / MINS_PER_HOUR + longint'(zone);
      days       = hours / HOURS_PER_DAY;
      jdn        = days + JDN_EPOCH_BIAS;
      cycles_400 = (4 * jdn + 3) / DAYS_PER_400Y;
      rest_400   = jdn - (DAYS_PER_400Y * cycles_400) / 4;
      cycles_4   = (4 * rest_400 + 3) / DAYS_PER_4Y;
      rest_4     = rest_400 - (DAYS_PER_4Y * cycles_4) / 4;
      month_step = (5 * rest_4 + 2) / DAYS_PER_5MON;
      wrap       = month_step / MONTH_WRAP_STEP;
      f.pad   = '0;
      f.sec   = SEC_W'(secs % SECS_PER_MIN);
      f.min   = MIN_W'(mins % MINS_PER_HOUR);
      f.hour  = HOUR_W'(hours % HOURS_PER_DAY);
      f.day   = DAY_W'(rest_4 - (DAYS_PER_5MON * month_step + 2) / 5 + 1);
      f.month = MONTH_W'(month_step + MARCH_BASE - MONTHS_PER_YEAR * wrap);
      f.year  = YEAR_W'(YEARS_PER_CENTURY * cycles_400 + cycles_4 + wrap - YEAR_BIAS);
      return f;
   endfunction

   task automatic note_fault(input string what, input longint unsigned want,
                             input longint unsigned got);
      fault_count++;
      if (fault_count <= REPORT_MAX)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   task automatic compare_field(input string what, input longint unsigned want,
                                input longint unsigned got);
      if (want !== got)
         note_fault(what, want, got);
   endtask

   // Result checker: every accepted result is matched against the oldest
   // prediction.
   always @(posedge clock) begin
      civil_fields_type want, got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = civil_fields_type'(rsp_tdata);
         if (pending_dates.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_MAX)
               $display("%0t result with no item outstanding: %h", $realtime, rsp_tdata);
         end else begin
            want = pending_dates.pop_front();
            compare_field("second_of_minute", want.sec, got.sec);
            compare_field("minute_of_hour", want.min, got.min);
            compare_field("hour_of_day", want.hour, got.hour);
            compare_field("day_of_month", want.day, got.day);
            compare_field("month_of_year", want.month, got.month);
            compare_field("full_year", want.year, got.year);
            compare_field("padding bits", want.pad, got.pad);
            dates_checked++;
         end
      end
   end

   // Result receiver: stalls for a random number of cycles before each
   // result, unless the bench is in a calm stretch.
   initial begin : result_receiver
      int unsigned stall;
      rsp_tready = 1'b0;
      forever begin
         stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && !reset));
      end
   end

   // Sends one count of seconds after a random gap. The valid stays high
   // straight into the next item when the next gap is zero. The prediction
   // is taken with the zone offset in force when the item is accepted.
   task automatic send_stamp(input logic [SECS_W-1:0] stamp);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_dates.push_back(civil_from_unix(stamp, zone_hours));
      stamps_sent++;
   endtask

   // Drops the valid and lets every outstanding result come back, then waits
   // out the drain allowance, so the block is idle afterwards.
   task automatic drain_pipeline();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_dates.size() != 0)
         @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   // The zone register is only ever written with nothing in flight.
   task automatic write_zone(input logic [OFFSET_W-1:0] zone);
      drain_pipeline();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= zone;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      zone_hours = zone;
      zones_seen[zone] = 1'b1;
   endtask

   // Random counts: fully random values, values close to UTC midnight,
   // values close to local midnight under the current offset (where the
   // offset pushes the date over), and values near the top of the range.
   function automatic logic [SECS_W-1:0] draw_stamp();
      longint stamp;
      longint day_index;
      day_index = longint'($urandom_range(0, 49710));
      case ($urandom_range(0, 3))
         0: stamp = longint'($urandom);
         1: stamp = day_index * 86400 + longint'($urandom_range(0, 7200)) - 3600;
         2: stamp = day_index * 86400 - longint'(zone_hours) * 3600
                    + longint'($urandom_range(0, 240)) - 120;
         default: stamp = 64'hFFFF_FFFF - longint'($urandom_range(0, 200000));
      endcase
      if (stamp < 0)
         stamp = 0;
      if (stamp > 64'hFFFF_FFFF)
         stamp = 64'hFFFF_FFFF;
      return SECS_W'(stamp);
   endfunction

   // Calendar corners under the reset offset of eight hours: the epoch,
   // minute, hour and day rollovers, a leap day in a 400-year leap year,
   // the non-leap century year 2100, the signed 32-bit boundary and the top
   // of the unsigned range.
   task automatic test_reset_zone();
      logic [SECS_W-1:0] corners[$];
      zones_seen[zone_hours] = 1'b1;
      corners = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd57599, 32'd57600,
                  32'd86399, 32'd946684799, 32'd951782399, 32'd951782400,
                  32'd1072915199, 32'd2147483647, 32'd2147483648,
                  32'd4107542399, 32'd4107542400, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hFFFF_FFFE, 32'hFFFF_FFFF};
      foreach (corners[i])
         send_stamp(corners[i]);
   endtask

   // Offset extremes: no offset, fourteen hours, and fifteen,
   // which the register holds and which is applied without saturation.
   task automatic test_zone_extremes();
      logic [OFFSET_W-1:0] zones[$];
      logic [SECS_W-1:0]   stamps[$];
      zones  = '{4'd0, 4'd14, 4'd15};
      stamps = '{32'd0, 32'd32399, 32'd4107510000, 32'hFFFF_FFFF};
      foreach (zones[z]) begin
         write_zone(zones[z]);
         foreach (stamps[i])
            send_stamp(stamps[i]);
      end
   endtask

   // Random traffic in phases, each with a fresh offset. Every third phase
   // runs with no idling on either side, so back-to-back items are covered.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 8; phase++) begin
         write_zone(OFFSET_W'($urandom_range(0, 15)));
         calm = (phase % 3 == 2);
         repeat (100)
            send_stamp(draw_stamp());
         calm = 1'b0;
      end
   endtask

   // Safety net against a hung handshake.
   initial begin
      #1_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_zone();
      test_zone_extremes();
      test_random_traffic();

      drain_pipeline();
      if (pending_dates.size() != 0)
         note_fault("outstanding results", 0, pending_dates.size());

      $display("Converted %0d second counts, %0d results compared.",
               stamps_sent, dates_checked);
      $display("Zone offsets exercised (bit per offset): %b, failures: %0d.",
               zones_seen, fault_count);
      if (fault_count == 0 && dates_checked == stamps_sent)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
